[hw/rtl/aup_pkg.sv]
`timescale 1ns / 1ps
package aup_pkg;

	localparam int NUM_CHANS = 3;
	localparam int Q_BITS = 16;
	localparam int DIV_STAGES = 8;
	localparam int STEP_BITS = Q_BITS / DIV_STAGES;
	// prep, divider steps, 8-bit reduction
	localparam int STAGES = DIV_STAGES + 2;

	localparam logic [15:0] FULL16 = 16'hFFFF;
	localparam logic [16:0] HALF_STEP = 17'd128;
	localparam logic [17:0] DIV16TO8 = 18'd257;

	typedef struct packed {
		logic [15:0] chan0_in;
		logic [15:0] chan1_in;
		logic [15:0] chan2_in;
		logic [15:0] alpha_in;
		logic last_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] chan0_out;
		logic [7:0] chan1_out;
		logic [7:0] chan2_out;
		logic [7:0] alpha_out;
		logic last_out;
	} pix_out_t;

	typedef struct packed {
		logic [STAGES-1:0] load;
		logic out_load;
	} pipe_ctl_t;

	// (x + 128) / 257: estimate by shifts, then one correction step
	function automatic logic [7:0] reduce8(input logic [15:0] x);
		logic [16:0] y;
		logic [16:0] est;
		logic [7:0] q0;
		logic [17:0] r;
		y = {1'b0, x} + HALF_STEP;
		est = (y - (y >> 8)) >> 8;
		q0 = est[7:0];
		r = {1'b0, y} - {2'b0, q0, 8'b0} - {10'b0, q0};
		if (r[17]) begin
			reduce8 = q0 - 8'd1;
		end else if (r >= DIV16TO8) begin
			reduce8 = q0 + 8'd1;
		end else begin
			reduce8 = q0;
		end
	endfunction

endpackage

[hw/rtl/aup_if.sv]
`timescale 1ns / 1ps
interface aup_in_if import aup_pkg::*; ();
	logic valid;
	logic ready;
	pix_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface aup_out_if import aup_pkg::*; ();
	logic valid;
	logic ready;
	pix_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/aup_ctrl.sv]
`timescale 1ns / 1ps
module aup_ctrl import aup_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output pipe_ctl_t ctl
);

	logic [STAGES-1:0] vld_q;
	logic out_vld_q;
	logic [STAGES:0] rdy;

	always_comb begin
		rdy[STAGES] = !out_vld_q || out_ready;
		for (int k = STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		ctl.load[0] = rdy[0] && in_valid;
		for (int k = 1; k < STAGES; k++) begin
			ctl.load[k] = rdy[k] && vld_q[k-1];
		end
		ctl.out_load = rdy[STAGES] && vld_q[STAGES-1];
	end

	assign in_ready = rdy[0];
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (rdy[STAGES]) begin
				out_vld_q <= vld_q[STAGES-1];
			end
		end
	end

endmodule

[hw/rtl/aup_lane.sv]
`timescale 1ns / 1ps
module aup_lane import aup_pkg::*; (
	input logic clk,
	input pipe_ctl_t ctl,
	input logic [15:0] chan,
	input logic [15:0] alpha,
	output logic [7:0] res
);

	logic [15:0] rem_s [DIV_STAGES+1];
	logic [Q_BITS-1:0] quo_s [DIV_STAGES+1];
	logic [15:0] div_s [DIV_STAGES+1];
	logic zero_s [DIV_STAGES+1];
	logic sat_s [DIV_STAGES+1];
	logic [7:0] res_s10;
	logic [31:0] num;
	logic [15:0] straight;

	// c * 65535 + alpha / 2
	assign num = {chan, 16'b0} - {16'b0, chan} + {17'b0, alpha[15:1]};

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			rem_s[0] <= num[31:16];
			quo_s[0] <= num[15:0];
			div_s[0] <= alpha;
			zero_s[0] <= (alpha == 16'd0);
			sat_s[0] <= (chan >= alpha);
		end
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		logic [15:0] rem_nxt;
		logic [Q_BITS-1:0] quo_nxt;

		always_comb begin
			logic [16:0] trial;
			rem_nxt = rem_s[j];
			quo_nxt = quo_s[j];
			for (int b = 0; b < STEP_BITS; b++) begin
				trial = {rem_nxt, quo_nxt[Q_BITS-1]};
				quo_nxt = {quo_nxt[Q_BITS-2:0], 1'b0};
				if (trial >= {1'b0, div_s[j]}) begin
					trial = trial - {1'b0, div_s[j]};
					quo_nxt[0] = 1'b1;
				end
				rem_nxt = trial[15:0];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.load[j+1]) begin
				rem_s[j+1] <= rem_nxt;
				quo_s[j+1] <= quo_nxt;
				div_s[j+1] <= div_s[j];
				zero_s[j+1] <= zero_s[j];
				sat_s[j+1] <= sat_s[j];
			end
		end
	end

	always_comb begin
		if (zero_s[DIV_STAGES]) begin
			straight = 16'd0;
		end else if (sat_s[DIV_STAGES]) begin
			straight = FULL16;
		end else begin
			straight = quo_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[STAGES-1]) begin
			res_s10 <= reduce8(straight);
		end
	end

	assign res = res_s10;

endmodule

[hw/rtl/aup_merge.sv]
`timescale 1ns / 1ps
module aup_merge import aup_pkg::*; (
	input logic clk,
	input pipe_ctl_t ctl,
	input logic [15:0] alpha,
	input logic last,
	input logic [7:0] lane_res [NUM_CHANS],
	output pix_out_t pix
);

	logic [7:0] alpha_s [STAGES];
	logic last_s [STAGES];
	pix_out_t pix_q;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			alpha_s[0] <= reduce8(alpha);
			last_s[0] <= last;
		end
		for (int k = 1; k < STAGES; k++) begin
			if (ctl.load[k]) begin
				alpha_s[k] <= alpha_s[k-1];
				last_s[k] <= last_s[k-1];
			end
		end
		if (ctl.out_load) begin
			pix_q.chan0_out <= lane_res[0];
			pix_q.chan1_out <= lane_res[1];
			pix_q.chan2_out <= lane_res[2];
			pix_q.alpha_out <= alpha_s[STAGES-1];
			pix_q.last_out <= last_s[STAGES-1];
		end
	end

	assign pix = pix_q;

endmodule

[hw/rtl/alpha_unpremultiply_16_to_8.sv]
`timescale 1ns / 1ps
// Each accepted word passes the prep, divider, reduction and output registers.
// Throughput: one pixel per cycle unless the output stalls; each color
// lane runs an 8-stage divider pipeline that retires two quotient bits per stage.
// Stalls back up stage by stage, so bubbles are squeezed out.
// Reset clears the valid bits only; the data path registers are not reset.
module alpha_unpremultiply_16_to_8 import aup_pkg::*; (
	input logic clk,
	input logic arst_n,
	aup_in_if.sink rgba16,
	aup_out_if.source rgba8
);

	pipe_ctl_t ctl;
	logic [15:0] chan [NUM_CHANS];
	logic [7:0] lane_res [NUM_CHANS];

	assign chan[0] = rgba16.data.chan0_in;
	assign chan[1] = rgba16.data.chan1_in;
	assign chan[2] = rgba16.data.chan2_in;

	aup_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rgba16.valid),
		.in_ready(rgba16.ready),
		.out_valid(rgba8.valid),
		.out_ready(rgba8.ready),
		.ctl(ctl)
	);

	for (genvar i = 0; i < NUM_CHANS; i++) begin : g_lane
		aup_lane u_lane (
			.clk(clk),
			.ctl(ctl),
			.chan(chan[i]),
			.alpha(rgba16.data.alpha_in),
			.res(lane_res[i])
		);
	end

	aup_merge u_merge (
		.clk(clk),
		.ctl(ctl),
		.alpha(rgba16.data.alpha_in),
		.last(rgba16.data.last_in),
		.lane_res(lane_res),
		.pix(rgba8.data)
	);

endmodule
